>>> rtl/scp_pkg.sv
// Shared types, constants and helpers for the sprite clip playback block.
// Depends on nothing; used by every module in rtl.
package scp_pkg;

   localparam int MAX_FRAMES_DEF = 8;

   localparam int TIME_W   = 16;
   localparam int SPEED_W  = 12;
   localparam int PROD_W   = TIME_W + SPEED_W;
   localparam int STEP_W   = 20;
   localparam int SUM_W    = STEP_W + 1;
   localparam int FRAME_W  = 3;
   localparam int COUNT_W  = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam int STARTS_W = 128;

   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_DURATION     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLAY_SPEED        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PLAY_MODE         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_STARTS_LOW  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_STARTS_HIGH = 3'd5;

   localparam logic [1:0] MODE_LOOP     = 2'd0;
   localparam logic [1:0] MODE_ONCE     = 2'd1;
   localparam logic [1:0] MODE_PINGPONG = 2'd2;

   localparam logic KIND_TICK    = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   localparam logic [TIME_W-1:0]  DURATION_RESET = 16'd1024;
   localparam logic [SPEED_W-1:0] SPEED_RESET    = 12'd256;
   localparam logic [COUNT_W-1:0] COUNT_RESET    = 4'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_MOD,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              kind;
      logic [TIME_W-1:0] time_step;
   } req_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame_index;
      logic               frame_changed;
      logic               moving_backward;
      logic               still_playing;
      logic [TIME_W-1:0]  play_position;
   } rsp_type;

   function automatic logic [TIME_W-1:0] frame_start(input logic [STARTS_W-1:0] starts,
                                                     input logic [FRAME_W-1:0] idx);
      return starts[{idx, 4'b0000} +: TIME_W];
   endfunction

endpackage

>>> rtl/sprite_clip_playback_top.sv
// Top level of the sprite clip playback block: handshakes, registers, sequencer.
// Depends on scp_pkg and scp_serial_mod.
//
// Keyframe clip playback. A tick item scales its time step by the clip speed
// with a shift-add multiplier taking one speed bit a cycle, adds it to the
// play position (subtracts it when moving back in ping-pong mode), and in loop
// mode reduces the sum modulo the duration in a bit-serial remainder unit.
// The shown frame is then found by walking the start times, one frame a cycle.
// A restart or a tick while stopped goes straight to its result.
// One item is in work at a time; a new item is taken while the previous result
// still waits in the output register. Configuration writes are taken at once.
module sprite_clip_playback_top #(
   parameter int MAX_FRAMES = scp_pkg::MAX_FRAMES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  scp_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output scp_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [scp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [scp_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int TW = scp_pkg::TIME_W;
   localparam int CW = scp_pkg::COUNT_W;
   localparam int FW = scp_pkg::FRAME_W;
   localparam logic [CW-1:0] MAX_N = CW'(MAX_FRAMES);
   localparam logic [3:0] MUL_LAST = 4'(scp_pkg::SPEED_W - 1);

   scp_pkg::state_type state_ff, state_in;

   logic [TW-1:0]                  duration_ff;
   logic [scp_pkg::SPEED_W-1:0]    speed_ff;
   logic [1:0]                     mode_ff;
   logic [CW-1:0]                  count_ff;
   logic [scp_pkg::STARTS_W-1:0]   starts_ff;

   logic [TW-1:0] pos_ff, pos_in;
   logic [FW-1:0] frame_ff, frame_in;
   logic          back_ff, back_in;
   logic          play_ff, play_in;
   logic          changed_ff, changed_in;

   logic [scp_pkg::PROD_W-1:0]  acc_ff, acc_in;
   logic [scp_pkg::PROD_W-1:0]  mcand_ff, mcand_in;
   logic [scp_pkg::SPEED_W-1:0] mplier_ff, mplier_in;
   logic [3:0]                  mul_cnt_ff, mul_cnt_in;
   logic [CW-1:0]               scan_ff, scan_in;
   logic [FW-1:0]               found_ff, found_in;

   logic                rsp_valid_ff, rsp_valid_in;
   scp_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   logic                       req_take;
   logic                       rsp_free;
   logic                       mod_start;
   logic                       mod_done;
   logic [TW-1:0]              mod_rem;
   logic [TW-1:0]              dur_eff;
   logic [CW-1:0]              n_eff;
   logic [scp_pkg::STEP_W-1:0] step;
   logic [scp_pkg::SUM_W-1:0]  sum;
   logic                       scan_hit;
   logic                       quiet;

   assign dur_eff  = (duration_ff == '0) ? TW'(1) : duration_ff;
   assign n_eff    = (count_ff > MAX_N) ? MAX_N : count_ff;
   assign step     = acc_ff[scp_pkg::PROD_W-1:8];
   assign sum      = scp_pkg::SUM_W'(pos_ff) + scp_pkg::SUM_W'(step);
   assign scan_hit = (scan_ff < n_eff) &&
                     (scp_pkg::frame_start(starts_ff, scan_ff[FW-1:0]) <= pos_ff);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign quiet    = (req_data.kind == scp_pkg::KIND_RESTART) || !play_ff ||
                     (count_ff == '0);

   scp_serial_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (sum),
      .divisor   (dur_eff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         scp_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = quiet ? scp_pkg::ST_DONE : scp_pkg::ST_MUL;
            end
         end
         scp_pkg::ST_MUL: begin
            if (mul_cnt_ff == MUL_LAST) begin
               state_in = scp_pkg::ST_SUM;
            end
         end
         scp_pkg::ST_SUM: begin
            state_in = (mode_ff == scp_pkg::MODE_LOOP) ? scp_pkg::ST_MOD : scp_pkg::ST_SCAN;
         end
         scp_pkg::ST_MOD: begin
            if (mod_done) begin
               state_in = scp_pkg::ST_SCAN;
            end
         end
         scp_pkg::ST_SCAN: begin
            if (!scan_hit) begin
               state_in = scp_pkg::ST_DONE;
            end
         end
         scp_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = scp_pkg::ST_IDLE;
            end
         end
         default: state_in = scp_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall = (state_ff != scp_pkg::ST_IDLE);
      mod_start = (state_ff == scp_pkg::ST_SUM) && (mode_ff == scp_pkg::MODE_LOOP);
      csr_ready = 1'b1;
   end

   assign req_take = req_valid && !req_stall;

   // datapath
   always_comb begin
      pos_in       = pos_ff;
      frame_in     = frame_ff;
      back_in      = back_ff;
      play_in      = play_ff;
      changed_in   = changed_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      mul_cnt_in   = mul_cnt_ff;
      scan_in      = scan_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         scp_pkg::ST_IDLE: begin
            if (req_take) begin
               changed_in = 1'b0;
               acc_in     = '0;
               mcand_in   = scp_pkg::PROD_W'(req_data.time_step);
               mplier_in  = speed_ff;
               mul_cnt_in = '0;
               if (req_data.kind == scp_pkg::KIND_RESTART) begin
                  changed_in = (frame_ff != '0);
                  pos_in     = '0;
                  frame_in   = '0;
                  back_in    = 1'b0;
                  play_in    = 1'b1;
               end
            end
         end
         scp_pkg::ST_MUL: begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in   = mcand_ff << 1;
            mplier_in  = mplier_ff >> 1;
            mul_cnt_in = mul_cnt_ff + 1'b1;
         end
         scp_pkg::ST_SUM: begin
            scan_in  = '0;
            found_in = '0;
            case (mode_ff)
               scp_pkg::MODE_ONCE: begin
                  if (sum >= scp_pkg::SUM_W'(dur_eff)) begin
                     pos_in  = dur_eff;
                     play_in = 1'b0;
                  end else begin
                     pos_in = sum[TW-1:0];
                  end
               end
               scp_pkg::MODE_PINGPONG: begin
                  if (!back_ff) begin
                     if (sum >= scp_pkg::SUM_W'(dur_eff)) begin
                        pos_in  = dur_eff;
                        back_in = 1'b1;
                     end else begin
                        pos_in = sum[TW-1:0];
                     end
                  end else if (step >= scp_pkg::STEP_W'(pos_ff)) begin
                     pos_in  = '0;
                     back_in = 1'b0;
                  end else begin
                     pos_in = pos_ff - step[TW-1:0];
                  end
               end
               default: begin
               end
            endcase
         end
         scp_pkg::ST_MOD: begin
            if (mod_done) begin
               pos_in = mod_rem;
            end
         end
         scp_pkg::ST_SCAN: begin
            if (scan_hit) begin
               found_in = scan_ff[FW-1:0];
               scan_in  = scan_ff + 1'b1;
            end else if (found_ff != frame_ff) begin
               back_in    = (found_ff < frame_ff);
               frame_in   = found_ff;
               changed_in = 1'b1;
            end
         end
         scp_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.frame_index     = frame_ff;
               rsp_data_in.frame_changed   = changed_ff;
               rsp_data_in.moving_backward = back_ff;
               rsp_data_in.still_playing   = play_ff;
               rsp_data_in.play_position   = pos_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         frame_ff     <= '0;
         back_ff      <= 1'b0;
         play_ff      <= 1'b1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         frame_ff     <= frame_in;
         back_ff      <= back_in;
         play_ff      <= play_in;
      end
      changed_ff  <= changed_in;
      acc_ff      <= acc_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      mul_cnt_ff  <= mul_cnt_in;
      scan_ff     <= scan_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff <= scp_pkg::DURATION_RESET;
         speed_ff    <= scp_pkg::SPEED_RESET;
         mode_ff     <= scp_pkg::MODE_LOOP;
         count_ff    <= scp_pkg::COUNT_RESET;
         starts_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            scp_pkg::CSR_CLIP_DURATION:     duration_ff <= csr_data[TW-1:0];
            scp_pkg::CSR_PLAY_SPEED:        speed_ff    <= csr_data[scp_pkg::SPEED_W-1:0];
            scp_pkg::CSR_PLAY_MODE:         mode_ff     <= csr_data[1:0];
            scp_pkg::CSR_FRAME_COUNT:       count_ff    <= csr_data[CW-1:0];
            scp_pkg::CSR_FRAME_STARTS_LOW:  starts_ff[63:0]   <= csr_data;
            scp_pkg::CSR_FRAME_STARTS_HIGH: starts_ff[127:64] <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/scp_serial_mod.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on scp_pkg.
module scp_serial_mod (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [scp_pkg::SUM_W-1:0]   dividend,
   input  logic [scp_pkg::TIME_W-1:0]  divisor,
   output logic                        done,
   output logic [scp_pkg::TIME_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(scp_pkg::SUM_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(scp_pkg::SUM_W - 1);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [scp_pkg::SUM_W-1:0]  dvd_ff, dvd_in;
   logic [scp_pkg::TIME_W-1:0] dvs_ff, dvs_in;
   logic [scp_pkg::TIME_W-1:0] rem_ff, rem_in;
   logic [scp_pkg::TIME_W:0]   trial;

   always_comb begin
      trial   = {rem_ff, dvd_ff[scp_pkg::SUM_W-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = dvd_ff << 1;
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = scp_pkg::TIME_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[scp_pkg::TIME_W-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for sprite_clip_playback_top: directed table, then random clips.
// Depends on rtl/scp_pkg.sv and the block itself; results are checked against a local clip model.
module testbench;
   import scp_pkg::*;

   localparam logic [1:0]           MODE_SPARE   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_7 = 3'd7;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 60;
   localparam int HOLD_CYCLES   = 400;

   typedef enum logic [1:0] {DO_WRITE, DO_ITEM, DO_CHECKED} plan_op_type;

   typedef struct packed {
      plan_op_type           op;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] value;
      req_type               item;
      rsp_type               want;
   } plan_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   logic [TIME_W-1:0]   cfg_duration = DURATION_RESET;
   logic [SPEED_W-1:0]  cfg_speed = SPEED_RESET;
   logic [1:0]          cfg_mode = MODE_LOOP;
   logic [COUNT_W-1:0]  cfg_count = COUNT_RESET;
   logic [STARTS_W-1:0] cfg_starts = '0;

   int unsigned clip_pos = 0;
   int unsigned clip_frame = 0;
   bit clip_back = 1'b0;
   bit clip_live = 1'b1;

   rsp_type owed_reports [$];
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   bit hold_wanted = 1'b0;
   bit hold_done = 1'b0;
   int faults = 0;
   int items_sent = 0;
   int restarts_sent = 0;
   int reports_seen = 0;
   int reg_writes = 0;

   plan_row_type plan_rows [41] = '{
      '{DO_CHECKED, '0, '0, '{KIND_TICK, 16'd0}, '{3'd0, 1'b0, 1'b0, 1'b1, 16'd0}},
      '{DO_CHECKED, '0, '0, '{KIND_TICK, 16'd1000}, '{3'd0, 1'b0, 1'b0, 1'b1, 16'd1000}},
      '{DO_CHECKED, '0, '0, '{KIND_TICK, 16'd24}, '{3'd0, 1'b0, 1'b0, 1'b1, 16'd0}},
      '{DO_CHECKED, '0, '0, '{KIND_TICK, 16'hFFFF}, '{3'd0, 1'b0, 1'b0, 1'b1, 16'd1023}},
      '{DO_CHECKED, '0, '0, '{KIND_RESTART, 16'hFFFF}, '{3'd0, 1'b0, 1'b0, 1'b1, 16'd0}},
      '{DO_WRITE, CSR_CLIP_DURATION, 64'd0, '0, '0},
      '{DO_WRITE, CSR_PLAY_SPEED, 64'd4095, '0, '0},
      '{DO_CHECKED, '0, '0, '{KIND_TICK, 16'hFFFF}, '{3'd0, 1'b0, 1'b0, 1'b1, 16'd0}},
      '{DO_WRITE, CSR_PLAY_MODE, 64'(MODE_ONCE), '0, '0},
      '{DO_WRITE, CSR_CLIP_DURATION, 64'd65535, '0, '0},
      '{DO_WRITE, CSR_FRAME_COUNT, 64'd15, '0, '0},
      '{DO_WRITE, CSR_FRAME_STARTS_LOW, 64'h0BB8_07D0_03E8_0000, '0, '0},
      '{DO_WRITE, CSR_FRAME_STARTS_HIGH, 64'h9C40_7530_4E20_2710, '0, '0},
      '{DO_ITEM, '0, '0, '{KIND_TICK, 16'd100}, '0},
      '{DO_ITEM, '0, '0, '{KIND_TICK, 16'hFFFF}, '0},
      '{DO_ITEM, '0, '0, '{KIND_TICK, 16'd5}, '0},
      '{DO_CHECKED, '0, '0, '{KIND_RESTART, 16'd0}, '{3'd0, 1'b1, 1'b0, 1'b1, 16'd0}},
      '{DO_WRITE, CSR_PLAY_MODE, 64'(MODE_PINGPONG), '0, '0},
      '{DO_WRITE, CSR_PLAY_SPEED, 64'd256, '0, '0},
      '{DO_WRITE, CSR_CLIP_DURATION, 64'd5000, '0, '0},
      '{DO_WRITE, CSR_FRAME_COUNT, 64'd4, '0, '0},
      '{DO_ITEM, '0, '0, '{KIND_TICK, 16'd2500}, '0},
      '{DO_ITEM, '0, '0, '{KIND_TICK, 16'd3000}, '0},
      '{DO_ITEM, '0, '0, '{KIND_TICK, 16'd4000}, '0},
      '{DO_ITEM, '0, '0, '{KIND_TICK, 16'd4500}, '0},
      '{DO_ITEM, '0, '0, '{KIND_TICK, 16'd600}, '0},
      '{DO_WRITE, CSR_PLAY_MODE, 64'(MODE_LOOP), '0, '0},
      '{DO_WRITE, CSR_FRAME_STARTS_LOW, 64'h0000_0064_0258_0000, '0, '0},
      '{DO_ITEM, '0, '0, '{KIND_TICK, 16'd300}, '0},
      '{DO_ITEM, '0, '0, '{KIND_TICK, 16'd400}, '0},
      '{DO_WRITE, CSR_PLAY_MODE, 64'(MODE_SPARE), '0, '0},
      '{DO_ITEM, '0, '0, '{KIND_TICK, 16'hFFFF}, '0},
      '{DO_WRITE, CSR_FRAME_COUNT, 64'd0, '0, '0},
      '{DO_WRITE, CSR_PLAY_MODE, 64'(MODE_LOOP), '0, '0},
      '{DO_ITEM, '0, '0, '{KIND_TICK, 16'd1234}, '0},
      '{DO_WRITE, CSR_UNUSED_6, '1, '0, '0},
      '{DO_WRITE, CSR_UNUSED_7, '1, '0, '0},
      '{DO_WRITE, CSR_FRAME_COUNT, 64'd1, '0, '0},
      '{DO_ITEM, '0, '0, '{KIND_TICK, 16'd9999}, '0},
      '{DO_WRITE, CSR_PLAY_SPEED, 64'd0, '0, '0},
      '{DO_ITEM, '0, '0, '{KIND_TICK, 16'hFFFF}, '0}
   };

   sprite_clip_playback_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   task automatic advance_clip(input req_type item, output rsp_type report);
      int unsigned n;
      int unsigned span;
      int unsigned step;
      int unsigned total;
      int unsigned next_frame;
      bit changed;
      changed = 1'b0;
      if (item.kind == KIND_RESTART) begin
         changed = (clip_frame != 0);
         clip_pos = 0;
         clip_frame = 0;
         clip_back = 1'b0;
         clip_live = 1'b1;
      end else if (clip_live && cfg_count != 0) begin
         n = (cfg_count > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : cfg_count;
         span = (cfg_duration == 0) ? 1 : cfg_duration;
         step = (32'(item.time_step) * 32'(cfg_speed)) >> 8;
         total = clip_pos + step;
         case (cfg_mode)
            MODE_LOOP: clip_pos = total % span;
            MODE_ONCE: begin
               if (total >= span) begin
                  clip_pos = span;
                  clip_live = 1'b0;
               end else begin
                  clip_pos = total;
               end
            end
            MODE_PINGPONG: begin
               if (!clip_back) begin
                  if (total >= span) begin
                     clip_pos = span;
                     clip_back = 1'b1;
                  end else begin
                     clip_pos = total;
                  end
               end else if (step >= clip_pos) begin
                  clip_pos = 0;
                  clip_back = 1'b0;
               end else begin
                  clip_pos = clip_pos - step;
               end
            end
            default: ;
         endcase
         next_frame = 0;
         for (int i = 0; i < n; i++) begin
            if (cfg_starts[i*16 +: 16] <= clip_pos) next_frame = i;
            else break;
         end
         if (next_frame != clip_frame) begin
            clip_back = (next_frame < clip_frame);
            clip_frame = next_frame;
            changed = 1'b1;
         end
      end
      report.frame_index = FRAME_W'(clip_frame);
      report.frame_changed = changed;
      report.moving_backward = clip_back;
      report.still_playing = clip_live;
      report.play_position = TIME_W'(clip_pos);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_CLIP_DURATION:     cfg_duration = value[TIME_W-1:0];
         CSR_PLAY_SPEED:        cfg_speed = value[SPEED_W-1:0];
         CSR_PLAY_MODE:         cfg_mode = value[1:0];
         CSR_FRAME_COUNT:       cfg_count = value[COUNT_W-1:0];
         CSR_FRAME_STARTS_LOW:  cfg_starts[63:0] = value;
         CSR_FRAME_STARTS_HIGH: cfg_starts[127:64] = value;
         default: ;
      endcase
      reg_writes++;
   endtask

   task automatic send_item(input req_type item, input bit typed, input rsp_type want);
      rsp_type report;
      csr_valid <= 1'b0;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_clip(item, report);
      owed_reports.push_back(typed ? want : report);
      items_sent++;
      if (item.kind == KIND_RESTART) restarts_sent++;
   endtask

   task automatic drain_reports();
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      while (owed_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_wanted && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         reports_seen++;
         if (owed_reports.size() == 0) begin
            $error("unexpected result transfer %p", rsp_data);
            faults++;
         end else begin
            want = owed_reports.pop_front();
            if (rsp_data.frame_index !== want.frame_index) begin
               $error("frame_index expected %0d actual %0d",
                      want.frame_index, rsp_data.frame_index);
               faults++;
            end
            if (rsp_data.frame_changed !== want.frame_changed) begin
               $error("frame_changed expected %0d actual %0d",
                      want.frame_changed, rsp_data.frame_changed);
               faults++;
            end
            if (rsp_data.moving_backward !== want.moving_backward) begin
               $error("moving_backward expected %0d actual %0d",
                      want.moving_backward, rsp_data.moving_backward);
               faults++;
            end
            if (rsp_data.still_playing !== want.still_playing) begin
               $error("still_playing expected %0d actual %0d",
                      want.still_playing, rsp_data.still_playing);
               faults++;
            end
            if (rsp_data.play_position !== want.play_position) begin
               $error("play_position expected %0d actual %0d",
                      want.play_position, rsp_data.play_position);
               faults++;
            end
         end
      end
   end

   initial begin : stimulus
      int unsigned span;
      int unsigned swap;
      int unsigned marks [8];
      logic [STARTS_W-1:0] starts;
      logic [1:0] mode;
      req_type item;
      bit prev_item;
      int i;
      int j;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      prev_item = 1'b0;
      foreach (plan_rows[r]) begin
         if (plan_rows[r].op == DO_WRITE) begin
            if (prev_item) drain_reports();
            write_reg(plan_rows[r].idx, plan_rows[r].value);
            prev_item = 1'b0;
         end else begin
            send_item(plan_rows[r].item, plan_rows[r].op == DO_CHECKED, plan_rows[r].want);
            prev_item = 1'b1;
         end
      end

      for (int stage = 0; stage < 3; stage++) begin
         req_idle_pct = (stage == 0) ? 34 : (stage == 1) ? 62 : 0;
         rsp_idle_pct = (stage == 0) ? 62 : (stage == 1) ? 34 : 0;
         for (int setting = 0; setting < 4; setting++) begin
            drain_reports();
            case ($urandom_range(0, 5))
               0:       span = 0;
               1:       span = 65535;
               2, 3:    span = $urandom_range(16, 4096);
               default: span = $urandom_range(1, 65535);
            endcase
            for (i = 0; i < 8; i++) marks[i] = $urandom_range(0, span);
            if ($urandom_range(0, 99) < 85) begin
               for (i = 1; i < 8; i++) begin
                  for (j = i; j > 0 && marks[j-1] > marks[j]; j--) begin
                     swap = marks[j];
                     marks[j] = marks[j-1];
                     marks[j-1] = swap;
                  end
               end
            end
            for (i = 0; i < 8; i++) starts[i*16 +: 16] = marks[i][15:0];
            mode = ($urandom_range(0, 9) == 0) ? MODE_SPARE
                                                : 2'($urandom_range(MODE_LOOP, MODE_PINGPONG));
            write_reg(CSR_CLIP_DURATION, 64'(span));
            case ($urandom_range(0, 5))
               0:       write_reg(CSR_PLAY_SPEED, 64'd0);
               1:       write_reg(CSR_PLAY_SPEED, 64'd4095);
               2, 3:    write_reg(CSR_PLAY_SPEED, 64'($urandom_range(128, 512)));
               default: write_reg(CSR_PLAY_SPEED, 64'($urandom_range(0, 4095)));
            endcase
            write_reg(CSR_PLAY_MODE, 64'(mode));
            write_reg(CSR_FRAME_COUNT, ($urandom_range(0, 9) == 0) ? 64'($urandom_range(0, 15))
                                                                 : 64'($urandom_range(1, 8)));
            write_reg(CSR_FRAME_STARTS_LOW, starts[63:0]);
            write_reg(CSR_FRAME_STARTS_HIGH, starts[127:64]);
            if ($urandom_range(0, 3) == 0)
               write_reg(CSR_IDX_W'($urandom_range(CSR_UNUSED_6, CSR_UNUSED_7)),
                         {$urandom, $urandom});
            if (stage == 2 && setting == 0) hold_wanted = 1'b1;
            for (int k = 0; k < 40; k++) begin
               item.kind = ($urandom_range(0, 11) == 0) ? KIND_RESTART : KIND_TICK;
               case ($urandom_range(0, 9))
                  6, 7:    item.time_step = TIME_W'($urandom_range(0, 65535));
                  8:       item.time_step = '0;
                  9:       item.time_step = '1;
                  default: item.time_step = TIME_W'($urandom_range(0, span / 6 + 32));
               endcase
               send_item(item, 1'b0, '0);
            end
         end
      end

      drain_reports();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d items (%0d restarts) over %0d register writes, %0d results compared.",
               items_sent, restarts_sent, reg_writes, reports_seen);
      $display("Loop, once, ping-pong and spare modes, with long receiver hold-off included.");
      if (faults == 0 && owed_reports.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
